>>> src/npoa_pkg.sv
// npoa_pkg: shared widths, the overdraw palette and output limits for the
// nearest palette overdraw average block. No dependencies.
package npoa_pkg;

    localparam int COLOR_W      = 24;
    localparam int LEVEL_W      = 5;
    localparam int AVG_W        = 13;
    localparam int PALETTE_SIZE = 20;
    localparam int DIST_W       = 18;

    localparam logic [AVG_W-1:0] AVG_MAX = 13'd8191;

    localparam logic [COLOR_W-1:0] PALETTE [PALETTE_SIZE] = '{
        24'h000055, 24'h0000AA, 24'h0000FF, 24'h0055FF, 24'h00AAFF,
        24'h00FFFF, 24'h00FFAA, 24'h00FF55, 24'h00FF00, 24'h55FF00,
        24'hAAFF00, 24'hFFFF00, 24'hFFAA00, 24'hFF7F00, 24'hFF5500,
        24'hFF0000, 24'hFF002A, 24'hFF0055, 24'hFF00AA, 24'hFF00FF
    };

endpackage

>>> src/npoa_ifs.sv
// npoa_ifs: valid/ready channel interfaces for pixel input and result output.
// Depends on npoa_pkg for the field widths.
interface npoa_pixel_if import npoa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;

    modport source (output valid, output pixel_color, output last_pixel, input ready);
    modport sink   (input valid, input pixel_color, input last_pixel, output ready);
endinterface

interface npoa_result_if import npoa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] overdraw_level;
    logic               frame_done;
    logic [AVG_W-1:0]   average_overdraw;

    modport source (output valid, output overdraw_level, output frame_done,
                    output average_overdraw, input ready);
    modport sink   (input valid, input overdraw_level, input frame_done,
                    input average_overdraw, output ready);
endinterface

>>> src/nearest_palette_overdraw_average_top.sv
// nearest_palette_overdraw_average_top: palette classifier with frame average.
// Depends on npoa_pkg and the channel interfaces in npoa_ifs.sv.
//
// Usage: each pixel transaction on "pixel" carries a 24-bit RGB color and a
// last_pixel flag. Each one yields exactly one transaction on "result": the
// overdraw level (nearest palette index plus one), and on the last pixel of a
// frame also frame_done and the frame mean level in fixed point with
// AVG_FRAC_BITS fraction bits. Accumulators saturate and clear after the
// last pixel.
// Timing: the palette search walks 20 entries x 3 color channels through one
// shared squarer/adder, then come one accumulate step and one load step. On
// the last pixel a restoring divider runs between those two steps, one
// quotient bit per cycle. pixel.ready is high only while idle, so the next
// pixel is accepted only once the current result is loaded.
// The result sits in an output register; the next pixel is accepted and
// searched while it waits, and a stalled receiver holds only the load step.
// Reset clears the accumulators and the result valid, and leaves the block idle.
module nearest_palette_overdraw_average_top
    import npoa_pkg::*;
#(
    parameter int MAX_PIXELS_LOG2 = 22,
    parameter int AVG_FRAC_BITS   = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    npoa_pixel_if.sink           pixel,
    npoa_result_if.source        result
);

    localparam int SUM_BITS = MAX_PIXELS_LOG2 + 5;
    localparam int CNT_BITS = MAX_PIXELS_LOG2 + 1;
    localparam int DW       = SUM_BITS + AVG_FRAC_BITS;
    localparam int QW       = (DW > AVG_W) ? DW : AVG_W;
    localparam int STEP_W   = $clog2(DW + 1);
    localparam int IDX_W    = $clog2(PALETTE_SIZE);

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ACCUM,
        S_DIV,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [COLOR_W-1:0]   pix_reg;
    logic                 last_reg;
    logic [1:0]           ch_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [DIST_W-1:0]    part_reg;
    logic [DIST_W-1:0]    best_reg;
    logic [LEVEL_W-1:0]   lvl_reg;
    logic [SUM_BITS-1:0]  sum_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [DW-1:0]        dvd_reg;
    logic [CNT_BITS-1:0]  rem_reg;
    logic [CNT_BITS-1:0]  den_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 out_valid_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    logic                 out_done_reg;
    logic [AVG_W-1:0]     out_avg_reg;

    logic [7:0]           chan_pix;
    logic [7:0]           chan_pal;
    logic [7:0]           chan_diff;
    logic [15:0]          chan_sq;
    logic [DIST_W-1:0]    dist_sum;
    logic [SUM_BITS:0]    sum_add;
    logic [SUM_BITS-1:0]  sum_sat;
    logic [CNT_BITS-1:0]  cnt_sat;
    logic [CNT_BITS:0]    rem_sh;
    logic                 rem_ge;
    logic [CNT_BITS:0]    rem_sub;
    logic [QW-1:0]        q_ext;
    logic [AVG_W-1:0]     avg_sat;
    logic                 out_free;

    always_comb
    begin
        case (ch_reg)
            CH_RED:
            begin
                chan_pix = pix_reg[23:16];
                chan_pal = PALETTE[idx_reg][23:16];
            end
            CH_GREEN:
            begin
                chan_pix = pix_reg[15:8];
                chan_pal = PALETTE[idx_reg][15:8];
            end
            default:
            begin
                chan_pix = pix_reg[7:0];
                chan_pal = PALETTE[idx_reg][7:0];
            end
        endcase
        chan_diff = (chan_pix >= chan_pal) ? (chan_pix - chan_pal) : (chan_pal - chan_pix);
        chan_sq   = 16'(chan_diff) * 16'(chan_diff);
        dist_sum  = part_reg + DIST_W'(chan_sq);

        sum_add = {1'b0, sum_reg} + (SUM_BITS + 1)'(lvl_reg);
        sum_sat = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
        cnt_sat = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;

        rem_sh  = {rem_reg, dvd_reg[DW-1]};
        rem_ge  = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};

        q_ext   = QW'(dvd_reg);
        avg_sat = (q_ext > QW'(AVG_MAX)) ? AVG_MAX : q_ext[AVG_W-1:0];

        out_free = !out_valid_reg || result.ready;
    end

    assign pixel.ready             = (state_reg == S_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.overdraw_level   = out_level_reg;
    assign result.frame_done       = out_done_reg;
    assign result.average_overdraw = out_avg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pix_reg       <= '0;
            last_reg      <= 1'b0;
            ch_reg        <= CH_RED;
            idx_reg       <= '0;
            part_reg      <= '0;
            best_reg      <= '1;
            lvl_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_level_reg <= '0;
            out_done_reg  <= 1'b0;
            out_avg_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pixel.valid)
                    begin
                        pix_reg   <= pixel.pixel_color;
                        last_reg  <= pixel.last_pixel;
                        ch_reg    <= CH_RED;
                        idx_reg   <= '0;
                        part_reg  <= '0;
                        best_reg  <= '1;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (ch_reg == CH_BLUE)
                    begin
                        if (dist_sum < best_reg)
                        begin
                            best_reg <= dist_sum;
                            lvl_reg  <= LEVEL_W'(idx_reg) + 1'b1;
                        end
                        part_reg <= '0;
                        ch_reg   <= CH_RED;
                        if (idx_reg == IDX_W'(PALETTE_SIZE - 1))
                        begin
                            state_reg <= S_ACCUM;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        part_reg <= dist_sum;
                        ch_reg   <= ch_reg + 1'b1;
                    end
                end
                S_ACCUM:
                begin
                    if (last_reg)
                    begin
                        dvd_reg   <= DW'(sum_sat) << AVG_FRAC_BITS;
                        den_reg   <= cnt_sat;
                        rem_reg   <= '0;
                        step_reg  <= STEP_W'(DW);
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        sum_reg   <= sum_sat;
                        cnt_reg   <= cnt_sat;
                        state_reg <= S_DONE;
                    end
                end
                S_DIV:
                begin
                    dvd_reg  <= {dvd_reg[DW-2:0], rem_ge};
                    rem_reg  <= rem_ge ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_level_reg <= lvl_reg;
                        out_done_reg  <= last_reg;
                        out_avg_reg   <= last_reg ? avg_sat : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.overdraw_level >= LEVEL_W'(1)) &&
                         (result.overdraw_level <= LEVEL_W'(PALETTE_SIZE)))
        else $error("overdraw level out of palette range");

    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.frame_done) |-> (result.average_overdraw == '0))
        else $error("average nonzero outside frame end");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> !pixel.ready)
        else $error("ready while a transaction is in progress");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("division by zero pixel count");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACCUM && last_reg) |=> (sum_reg == '0) && (cnt_reg == '0))
        else $error("accumulators not cleared at frame end");

endmodule

>>> tb/nearest_palette_overdraw_average_top_tb.sv
`timescale 1ns / 100ps
// Testbench for nearest_palette_overdraw_average_top: random pixel frames are driven and
// every result transaction is checked against an in-bench palette search and frame average.
// Depends on npoa_pkg, npoa_ifs.sv and the top level RTL.
module nearest_palette_overdraw_average_top_tb
    import npoa_pkg::*;
;
    localparam int MAX_PIXELS_LOG2 = 22;
    localparam int AVG_FRAC_BITS   = 8;
    localparam int SUM_W           = MAX_PIXELS_LOG2 + 5;
    localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
    localparam int RANDOM_ITEMS    = 900;
    localparam int SETTLE_CYCLES   = 120;

    localparam logic [23:0] OVERDRAW_COLORS [20] = '{
        24'h000055, 24'h0000AA, 24'h0000FF, 24'h0055FF, 24'h00AAFF,
        24'h00FFFF, 24'h00FFAA, 24'h00FF55, 24'h00FF00, 24'h55FF00,
        24'hAAFF00, 24'hFFFF00, 24'hFFAA00, 24'hFF7F00, 24'hFF5500,
        24'hFF0000, 24'hFF002A, 24'hFF0055, 24'hFF00AA, 24'hFF00FF
    };

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               done;
        logic [AVG_W-1:0]   avg;
    } frame_result_t;

    class frame_average_tracker;
        longint unsigned level_sum;
        longint unsigned pixel_count;
        frame_result_t   expected_results[$];
        int              mismatches;

        function new();
            level_sum   = 0;
            pixel_count = 0;
            mismatches  = 0;
        endfunction

        function logic [LEVEL_W-1:0] nearest_level(logic [23:0] rgb);
            int best;
            int d;
            int dr;
            int dg;
            int db;
            logic [LEVEL_W-1:0] lvl;
            best = 32'h7fffffff;
            lvl  = LEVEL_W'(1);
            for (int i = 0; i < 20; i++)
            begin
                dr = int'(rgb[23:16]) - int'(OVERDRAW_COLORS[i][23:16]);
                dg = int'(rgb[15:8])  - int'(OVERDRAW_COLORS[i][15:8]);
                db = int'(rgb[7:0])   - int'(OVERDRAW_COLORS[i][7:0]);
                d  = dr * dr + dg * dg + db * db;
                if (d < best)
                begin
                    best = d;
                    lvl  = LEVEL_W'(i + 1);
                end
            end
            return lvl;
        endfunction

        function void note_pixel(logic [23:0] rgb, logic last);
            frame_result_t   e;
            longint unsigned sum_max;
            longint unsigned cnt_max;
            longint unsigned q;
            sum_max = (64'd1 << SUM_W) - 1;
            cnt_max = (64'd1 << CNT_W) - 1;
            e.level = nearest_level(rgb);
            e.done  = last;
            e.avg   = '0;
            if (sum_max - level_sum < e.level)
                level_sum = sum_max;
            else
                level_sum = level_sum + e.level;
            if (pixel_count >= cnt_max)
                pixel_count = cnt_max;
            else
                pixel_count = pixel_count + 1;
            if (last)
            begin
                q = (level_sum << AVG_FRAC_BITS) / pixel_count;
                if (q > 8191)
                    q = 8191;
                e.avg       = AVG_W'(q);
                level_sum   = 0;
                pixel_count = 0;
            end
            expected_results.insert(expected_results.size(), e);
        endfunction

        function void check_result(logic [LEVEL_W-1:0] level, logic done,
                                   logic [AVG_W-1:0] avg);
            frame_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no pixel pending: overdraw_level %0d", level);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (level !== e.level)
            begin
                $error("overdraw_level: expected %0d, actual %0d", e.level, level);
                mismatches++;
            end
            if (done !== e.done)
            begin
                $error("frame_done: expected %0d, actual %0d", e.done, done);
                mismatches++;
            end
            if (avg !== e.avg)
            begin
                $error("average_overdraw: expected %0d, actual %0d", e.avg, avg);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;

    npoa_pixel_if  pix ();
    npoa_result_if res ();

    frame_average_tracker tracker;

    nearest_palette_overdraw_average_top #(
        .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2),
        .AVG_FRAC_BITS   (AVG_FRAC_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix),
        .result (res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 120);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    function automatic logic [23:0] make_pixel();
        int          r;
        int          a;
        int          b;
        int          v;
        logic [23:0] p;
        logic [23:0] q;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 24'($urandom());
        a = $urandom_range(0, 19);
        b = $urandom_range(0, 19);
        p = OVERDRAW_COLORS[a];
        if (r < 55)
            return p;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (r < 85)
                v = int'(p[ch*8 +: 8]) + int'($urandom_range(0, 16)) - 8;
            else
                v = (int'(p[ch*8 +: 8]) + int'(OVERDRAW_COLORS[b][ch*8 +: 8])) / 2;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            q[ch*8 +: 8] = 8'(v);
        end
        return q;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pixel(logic [23:0] rgb, logic last, int gap);
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel_color <= rgb;
        pix.last_pixel  <= last;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        tracker.note_pixel(rgb, last);
        @(negedge clk);
    endtask

    task automatic drain_results();
        pix.valid <= 1'b0;
        @(negedge clk);
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    // receiver side: random stalls, none while calm
    initial
    begin
        int stall_left;
        stall_left = 0;
        res.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                stall_left = 0;
                res.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                stall_left = idle_len() - 1;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            tracker.check_result(res.overdraw_level, res.frame_done, res.average_overdraw);
    end

    initial
    begin
        int sent;
        int flen;
        int r;
        tracker         = new();
        pix.valid       = 1'b0;
        pix.pixel_color = '0;
        pix.last_pixel  = 1'b0;
        rst_n           = 1'b0;
        calm            = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-pixel frame, then white, every palette color exactly, then ties
        send_pixel(24'h000000, 1'b1, sender_gap());
        send_pixel(24'hFFFFFF, 1'b0, sender_gap());
        for (int i = 0; i < 20; i++)
            send_pixel(OVERDRAW_COLORS[i], 1'b0, sender_gap());
        send_pixel(24'hFF6A00, 1'b0, sender_gap());
        send_pixel(24'hFF0015, 1'b1, sender_gap());
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                calm <= !calm;
            r = $urandom_range(0, 99);
            if (r < 85)
                flen = $urandom_range(1, 16);
            else if (r < 97)
                flen = $urandom_range(17, 80);
            else
                flen = $urandom_range(150, 300);
            if (flen > RANDOM_ITEMS - sent)
                flen = RANDOM_ITEMS - sent;
            for (int i = 0; i < flen; i++)
                send_pixel(make_pixel(), i == flen - 1, sender_gap());
            sent += flen;
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end
        pix.valid <= 1'b0;

        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
src/npoa_pkg.sv
src/npoa_ifs.sv
src/nearest_palette_overdraw_average_top.sv
tb/nearest_palette_overdraw_average_top_tb.sv
